// ===== hdl/twlc_pkg.sv =====
package twlc_pkg;

    // Default sizes of the cache, the backing memory and the register file.
    localparam int NUM_SETS_DEF  = 8;
    localparam int MEM_WORDS_DEF = 128;
    localparam int NUM_REGS_DEF  = 8;

    // Instruction word layout.
    localparam int INSTR_W  = 32;
    localparam int DATA_W   = 32;
    localparam int OPC_LSB  = 26;
    localparam int OPC_W    = 6;
    localparam int RT_LSB   = 16;
    localparam int RT_W     = 3;
    localparam int BYTE_LSB = 2;
    localparam int WADDR_W  = 14;

    localparam logic [OPC_W-1:0]  LOAD_OPCODE = 6'b100011;
    localparam logic [DATA_W-1:0] MEM_PRESET  = 32'd5;

    // Controller states.
    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_step;
        logic rd_en;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
    } t_status;

endpackage

// ===== hdl/twlc_ram.sv =====
module twlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/twlc_ctrl.sv =====
module twlc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  twlc_pkg::t_status i_status,
    output twlc_pkg::t_cmd    o_cmd
);

    import twlc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_status.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.rd_en = w_accept;
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The item is finished only when the output register is free.
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // An accepted item always moves on to the execute step.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted item did not reach execute");

    // A finished item shows up as a valid result in the next cycle.
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed item produced no result");

    // A commit never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while stalled");

    // The memory preset sweep ends in idle.
    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT && i_status.init_last) |=> (r_state == ST_IDLE))
        else $error("preset sweep did not finish");

endmodule

// ===== hdl/twlc_dp.sv =====
module twlc_dp #(
    parameter int NUM_SETS  = twlc_pkg::NUM_SETS_DEF,
    parameter int MEM_WORDS = twlc_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS  = twlc_pkg::NUM_REGS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twlc_pkg::t_cmd                i_cmd,
    output twlc_pkg::t_status             o_status,
    input  logic [twlc_pkg::INSTR_W-1:0]  i_instruction,
    output logic                          o_hit,
    output logic                          o_is_load,
    output logic [twlc_pkg::DATA_W-1:0]   o_load_value,
    output logic                          o_addr_error
);

    import twlc_pkg::*;

    // NUM_SETS is taken as a power of two: the set is the low address bits.
    localparam int SET_AW   = $clog2(NUM_SETS);
    localparam int MEM_AW   = $clog2(MEM_WORDS);
    localparam int RF_AW    = $clog2(NUM_REGS);
    localparam int TAG_W    = (MEM_AW > SET_AW) ? (MEM_AW - SET_AW) : 1;
    localparam int LINE_W   = TAG_W + DATA_W;
    localparam int INIT_LEN = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
    localparam int INIT_AW  = $clog2(INIT_LEN);
    localparam int RT_N     = 2 ** RT_W;

    logic [INSTR_W-1:0] r_ins;
    logic [INIT_AW-1:0] r_init_cnt;
    logic [NUM_SETS-1:0] r_valid [2];
    logic [NUM_SETS-1:0] r_mru0;
    logic               r_hit;
    logic               r_is_load;
    logic [DATA_W-1:0]  r_load_value;
    logic               r_addr_error;

    logic [RF_AW-1:0]   rt_map [RT_N];
    logic [WADDR_W-1:0] w_addr;
    logic               w_err;
    logic               w_load;
    logic [SET_AW-1:0]  w_set;
    logic [TAG_W-1:0]   w_tag;
    logic [RF_AW-1:0]   w_rt;
    logic [LINE_W-1:0]  line_rd [2];
    logic               line_we [2];
    logic [DATA_W-1:0]  mem_rd;
    logic [DATA_W-1:0]  rf_rd;
    logic               w_hit0, w_hit1, w_hit;
    logic               w_hit_way, w_victim, w_use_way;
    logic [DATA_W-1:0]  w_value;
    logic               w_ok;
    logic               w_line_wr;
    logic [DATA_W-1:0]  w_line_data;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic               rf_we;
    logic [RF_AW-1:0]   rf_waddr;
    logic [DATA_W-1:0]  rf_wdata;
    logic               w_init_mem, w_init_rf;

    // Register number wraps modulo the file size.
    for (genvar g = 0; g < RT_N; g++) begin : g_rt_map
        assign rt_map[g] = RF_AW'(g % NUM_REGS);
    end

    // Preset sweep counter after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
        end else if (i_cmd.init_step) begin
            r_init_cnt <= r_init_cnt + 1'b1;
        end
    end

    assign o_status.init_last = (r_init_cnt == INIT_AW'(INIT_LEN - 1));
    assign w_init_mem = i_cmd.init_step &&
                        ({1'b0, r_init_cnt} < (INIT_AW + 1)'(MEM_WORDS));
    assign w_init_rf  = i_cmd.init_step &&
                        ({1'b0, r_init_cnt} < (INIT_AW + 1)'(NUM_REGS));

    // Hold the instruction for the execute step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_ins <= i_instruction;
        end
    end

    // Decode of the held instruction.
    assign w_addr = r_ins[BYTE_LSB +: WADDR_W];
    assign w_err  = (w_addr >= WADDR_W'(MEM_WORDS));
    assign w_load = (r_ins[OPC_LSB +: OPC_W] == LOAD_OPCODE);
    assign w_set  = w_addr[SET_AW-1:0];
    assign w_tag  = w_addr[SET_AW +: TAG_W];
    assign w_rt   = rt_map[r_ins[RT_LSB +: RT_W]];

    // Tag compare; way 0 wins when both match.
    assign w_hit0    = r_valid[0][w_set] && (line_rd[0][DATA_W +: TAG_W] == w_tag);
    assign w_hit1    = r_valid[1][w_set] && (line_rd[1][DATA_W +: TAG_W] == w_tag);
    assign w_hit     = w_hit0 || w_hit1;
    assign w_hit_way = !w_hit0;

    // Victim: first invalid way, else the way not most recently used.
    always_comb begin
        priority if (!r_valid[0][w_set]) begin
            w_victim = 1'b0;
        end else if (!r_valid[1][w_set]) begin
            w_victim = 1'b1;
        end else begin
            w_victim = r_mru0[w_set];
        end
    end

    assign w_use_way = w_hit ? w_hit_way : w_victim;
    assign w_value   = w_hit ? (w_hit_way ? line_rd[1][DATA_W-1:0] : line_rd[0][DATA_W-1:0])
                             : mem_rd;
    assign w_ok      = i_cmd.commit && !w_err;

    // A line is written on a load miss (fill) or a store hit (update).
    assign w_line_wr   = w_ok && (w_load ? !w_hit : w_hit);
    assign w_line_data = w_load ? w_value : rf_rd;
    assign line_we[0]  = w_line_wr && !w_use_way;
    assign line_we[1]  = w_line_wr && w_use_way;

    // Backing memory: preset sweep, else a store miss.
    assign mem_we    = w_init_mem || (w_ok && !w_load && !w_hit);
    assign mem_waddr = i_cmd.init_step ? r_init_cnt[MEM_AW-1:0] : w_addr[MEM_AW-1:0];
    assign mem_wdata = i_cmd.init_step ? (DATA_W'(r_init_cnt) + MEM_PRESET) : rf_rd;

    // Register file: cleared by the sweep, else written by a load.
    assign rf_we    = w_init_rf || (w_ok && w_load);
    assign rf_waddr = i_cmd.init_step ? r_init_cnt[RF_AW-1:0] : w_rt;
    assign rf_wdata = i_cmd.init_step ? '0 : w_value;

    for (genvar w = 0; w < 2; w++) begin : g_way
        twlc_ram #(
            .WIDTH (LINE_W),
            .DEPTH (NUM_SETS)
        ) u_way_ram (
            .i_clk   (i_clk),
            .i_we    (line_we[w]),
            .i_waddr (w_set),
            .i_wdata ({w_tag, w_line_data}),
            .i_re    (i_cmd.rd_en),
            .i_raddr (i_instruction[BYTE_LSB +: SET_AW]),
            .o_rdata (line_rd[w])
        );
    end

    twlc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_instruction[BYTE_LSB +: MEM_AW]),
        .o_rdata (mem_rd)
    );

    twlc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_rf_ram (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rt_map[i_instruction[RT_LSB +: RT_W]]),
        .o_rdata (rf_rd)
    );

    // Valid bits and recency, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= '0;
            r_valid[1] <= '0;
            r_mru0     <= '0;
        end else begin
            if (w_line_wr) begin
                r_valid[w_use_way][w_set] <= 1'b1;
            end
            if (w_ok && (w_load || w_hit)) begin
                r_mru0[w_set] <= !w_use_way;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit        <= !w_err && w_hit;
            r_is_load    <= w_load;
            r_load_value <= (!w_err && w_load) ? w_value : '0;
            r_addr_error <= w_err;
        end
    end

    assign o_hit        = r_hit;
    assign o_is_load    = r_is_load;
    assign o_load_value = r_load_value;
    assign o_addr_error = r_addr_error;

endmodule

// ===== hdl/two_way_lru_cache_load_store.sv =====
// Two-way set-associative cache with LRU replacement in front of a word
// memory and a small register file, driven by load and store instructions.
// Input channel: i_in_valid / o_in_ready with i_instruction (opcode 100011 is
// a load, anything else a store; rt in bits 18..16, byte offset in 15..0).
// Output channel: o_out_valid / i_out_ready with o_hit, o_is_load,
// o_load_value and o_addr_error; one result item for every input item.
// Each accepted item has a synchronous read of the way, memory and
// register-file RAMs as it is accepted, then an execute step of compare and
// write-back that registers the result. A new item is accepted only once
// the previous one has left its execute step.
// After reset the block runs a preset sweep that loads each memory word with
// its address plus 5 and clears the register file; o_in_ready stays low
// meanwhile. If the receiver stalls, the result waits in the output register,
// and the next item is accepted but held in its execute step until the
// result is taken. NUM_SETS must be a power of two.
module two_way_lru_cache_load_store #(
    parameter int NUM_SETS  = twlc_pkg::NUM_SETS_DEF,
    parameter int MEM_WORDS = twlc_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS  = twlc_pkg::NUM_REGS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [twlc_pkg::INSTR_W-1:0]  i_instruction,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic                          o_is_load,
    output logic [twlc_pkg::DATA_W-1:0]   o_load_value,
    output logic                          o_addr_error
);

    import twlc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencing of the sweep, accept and execute steps.
    twlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arrays, compare and result register.
    twlc_dp #(
        .NUM_SETS  (NUM_SETS),
        .MEM_WORDS (MEM_WORDS),
        .NUM_REGS  (NUM_REGS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_instruction (i_instruction),
        .o_hit         (o_hit),
        .o_is_load     (o_is_load),
        .o_load_value  (o_load_value),
        .o_addr_error  (o_addr_error)
    );

endmodule
